// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define JSE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define JSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/jse_pkg.sv
// Shared types and constants for the JSON string escaper.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package jse_pkg;

    localparam int JSE_QUEUE_DEPTH = 2;

    // ASCII codes used by the escape rules
    localparam logic [6:0] CH_QUOTE  = 7'h22;
    localparam logic [6:0] CH_BSLASH = 7'h5C;
    localparam logic [6:0] CH_B      = 7'h62;
    localparam logic [6:0] CH_F      = 7'h66;
    localparam logic [6:0] CH_N      = 7'h6E;
    localparam logic [6:0] CH_R      = 7'h72;
    localparam logic [6:0] CH_T      = 7'h74;
    localparam logic [6:0] CH_U      = 7'h75;

    // What the back end has to spell out for one input byte
    typedef enum logic [1:0] {
        JOB_CHAR,   // one plain character
        JOB_ESC2,   // backslash + character
        JOB_UESC,   // \uXXXX of unit_hi
        JOB_UPAIR   // \uXXXX of unit_hi, then \uXXXX of unit_lo
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic        lower;    // lowercase hex digits
        logic [6:0]  ch;
        logic [15:0] unit_hi;
        logic [15:0] unit_lo;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_xfer;

endpackage

// File: hdl/jse_front.sv
// Front end: accepts input bytes, tracks UTF-8 sequences, classifies into jobs.
// Depends on jse_pkg.
`timescale 1ns / 1ps

module jse_front
    import jse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_string_start,
    input  logic       i_q_full,
    output t_job_xfer  o_push
);

    logic [1:0]  r_pend;
    logic [20:0] r_cp;
    logic [1:0]  n_pend;
    logic [20:0] n_cp;
    logic [1:0]  pend_eff;
    logic [20:0] cp_eff;
    logic [20:0] cp_cont;
    logic [20:0] cp_ofs;
    logic        emit;
    logic        accept;
    t_job        job;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        pend_eff = i_string_start ? 2'd0 : r_pend;
        cp_eff   = i_string_start ? 21'd0 : r_cp;
        cp_cont  = {cp_eff[14:0], i_in_byte[5:0]};
        cp_ofs   = cp_cont - 21'h10000;
        n_pend   = pend_eff;
        n_cp     = cp_eff;
        emit     = 1'b0;
        job.kind    = JOB_UESC;
        job.lower   = 1'b0;
        job.ch      = i_in_byte[6:0];
        job.unit_hi = 16'hFFFD;
        job.unit_lo = 16'h0000;

        if (pend_eff != 2'd0) begin
            // continuation byte, taken blindly
            n_pend = pend_eff - 2'd1;
            n_cp   = cp_cont;
            if (n_pend == 2'd0) begin
                emit = 1'b1;
                n_cp = 21'd0;
                if (cp_cont[20:16] == 5'd0) begin
                    job.kind    = JOB_UESC;
                    job.unit_hi = cp_cont[15:0];
                end else begin
                    job.kind    = JOB_UPAIR;
                    job.unit_hi = 16'hD800 | {5'd0, cp_ofs[20:10]};
                    job.unit_lo = 16'hDC00 | {6'd0, cp_ofs[9:0]};
                end
            end
        end else if (i_in_byte == {1'b0, CH_QUOTE} || i_in_byte == {1'b0, CH_BSLASH}) begin
            emit     = 1'b1;
            job.kind = JOB_ESC2;
        end else if (i_in_byte == 8'h08) begin
            emit = 1'b1; job.kind = JOB_ESC2; job.ch = CH_B;
        end else if (i_in_byte == 8'h0C) begin
            emit = 1'b1; job.kind = JOB_ESC2; job.ch = CH_F;
        end else if (i_in_byte == 8'h0A) begin
            emit = 1'b1; job.kind = JOB_ESC2; job.ch = CH_N;
        end else if (i_in_byte == 8'h0D) begin
            emit = 1'b1; job.kind = JOB_ESC2; job.ch = CH_R;
        end else if (i_in_byte == 8'h09) begin
            emit = 1'b1; job.kind = JOB_ESC2; job.ch = CH_T;
        end else if (i_in_byte < 8'h20) begin
            emit        = 1'b1;
            job.kind    = JOB_UESC;
            job.lower   = 1'b1;
            job.unit_hi = {8'h00, i_in_byte};
        end else if (i_in_byte < 8'h80) begin
            emit     = 1'b1;
            job.kind = JOB_CHAR;
        end else if (i_in_byte inside {[8'hC0:8'hDF]}) begin
            n_pend = 2'd1;
            n_cp   = {16'd0, i_in_byte[4:0]};
        end else if (i_in_byte inside {[8'hE0:8'hEF]}) begin
            n_pend = 2'd2;
            n_cp   = {17'd0, i_in_byte[3:0]};
        end else if (i_in_byte inside {[8'hF0:8'hF7]}) begin
            n_pend = 2'd3;
            n_cp   = {18'd0, i_in_byte[2:0]};
        end else begin
            // bad lead byte -> replacement character
            emit = 1'b1;
        end
    end

    assign o_push.valid = accept && emit;
    assign o_push.job   = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
            r_cp   <= 21'd0;
        end else if (accept) begin
            r_pend <= n_pend;
            r_cp   <= n_cp;
        end
    end

endmodule

// File: hdl/jse_queue.sv
// Short job queue between front and back end, built from registers.
// Depends on jse_pkg.
`timescale 1ns / 1ps

module jse_queue
    import jse_pkg::*;
#(
    parameter int DEPTH = JSE_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job_xfer i_push,
    output logic      o_full,
    output t_job_xfer o_head,
    input  logic      i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          empty;
    logic          push_ok;
    logic          pop_ok;

    assign o_full  = (r_count == CW'(DEPTH));
    assign empty   = (r_count == '0);
    assign push_ok = i_push.valid && !o_full;
    assign pop_ok  = i_pop && !empty;

    assign o_head.valid = !empty;
    assign o_head.job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (pop_ok) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + CW'(1);
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= i_push.job;
        end
    end

endmodule

// File: hdl/jse_back.sv
// Back end: spells out one job as ASCII characters, one per cycle while the
// output is not stalled, into an output register. Depends on jse_pkg.
`timescale 1ns / 1ps

module jse_back
    import jse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job_xfer  i_head,
    output logic       o_pop,
    output logic       o_busy,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [6:0] o_out_char,
    output logic       o_last_of_run
);

    function automatic logic [6:0] hex_digit(input logic [3:0] nib, input logic lower);
        logic [6:0] alpha;
        alpha = lower ? 7'h61 : 7'h41;
        if (nib < 4'd10) begin
            hex_digit = 7'h30 + {3'd0, nib};
        end else begin
            hex_digit = alpha + {3'd0, nib} - 7'd10;
        end
    endfunction

    t_job       r_job;
    logic       r_busy;
    logic [3:0] r_idx;
    logic       r_ovalid;
    logic [6:0] r_ochar;
    logic       r_olast;

    logic        adv;
    logic        is_last;
    logic [3:0]  len_m1;
    logic [2:0]  pos;
    logic [15:0] unit;
    logic [6:0]  cur;

    always_comb begin
        case (r_job.kind)
            JOB_CHAR:  len_m1 = 4'd0;
            JOB_ESC2:  len_m1 = 4'd1;
            JOB_UESC:  len_m1 = 4'd5;
            JOB_UPAIR: len_m1 = 4'd11;
            default:   len_m1 = 4'd0;
        endcase
    end

    // position inside a \uXXXX group; second group of a pair starts at six
    assign pos  = (r_idx >= 4'd6) ? 3'(r_idx - 4'd6) : r_idx[2:0];
    assign unit = (r_idx >= 4'd6) ? r_job.unit_lo : r_job.unit_hi;

    always_comb begin
        case (r_job.kind)
            JOB_CHAR: cur = r_job.ch;
            JOB_ESC2: cur = (r_idx == 4'd0) ? CH_BSLASH : r_job.ch;
            default: begin
                case (pos)
                    3'd0:    cur = CH_BSLASH;
                    3'd1:    cur = CH_U;
                    3'd2:    cur = hex_digit(unit[15:12], r_job.lower);
                    3'd3:    cur = hex_digit(unit[11:8], r_job.lower);
                    3'd4:    cur = hex_digit(unit[7:4], r_job.lower);
                    3'd5:    cur = hex_digit(unit[3:0], r_job.lower);
                    default: cur = CH_BSLASH;
                endcase
            end
        endcase
    end

    assign adv     = r_busy && (!r_ovalid || i_out_ready);
    assign is_last = (r_idx == len_m1);
    assign o_pop   = i_head.valid && (!r_busy || (adv && is_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= 4'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (adv) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= 4'd0;
            end else if (adv) begin
                if (is_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head.job;
        end
        if (adv) begin
            r_ochar <= cur;
            r_olast <= is_last;
        end
    end

    assign o_busy        = r_busy;
    assign o_out_valid   = r_ovalid;
    assign o_out_char    = r_ochar;
    assign o_last_of_run = r_olast;

endmodule

// File: hdl/json_string_escaper_utf8_unit.sv
// Channel | Direction | Handshake               | Payload
// --------+-----------+-------------------------+------------------------------
// in      | input     | i_in_valid / o_in_ready | i_in_byte, i_string_start
// out     | output    | o_out_valid/i_out_ready | o_out_char, o_last_of_run
//
// One input transfer per cycle while the job queue has room. Each byte that
// yields text emits 1 (plain), 2 (short escape), 6 (\uXXXX) or 12 (surrogate
// pair) characters, set by the back-end character sequencer and sent one per
// cycle while the output is not stalled. Lead and non-final continuation bytes
// yield nothing. Reset is synchronous, active low; no clearing pass. Either
// side may stall: the queue decouples them, and input stalls only when the
// queue is full.
// Top level of the JSON string escaper; depends on jse_pkg, jse_front,
// jse_queue, jse_back and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module json_string_escaper_utf8_unit
    import jse_pkg::*;
#(
    parameter int Q_DEPTH = JSE_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_string_start,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [6:0] o_out_char,
    output logic       o_last_of_run
);

    t_job_xfer w_push;     // front -> queue
    t_job_xfer w_head;     // queue -> back
    logic      w_q_full;
    logic      w_pop;
    logic      w_back_busy;

    // Front end: UTF-8 sequence tracking and escape classification
    jse_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .i_string_start (i_string_start),
        .i_q_full       (w_q_full),
        .o_push         (w_push)
    );

    // Job queue lets the front keep taking bytes while escapes drain
    jse_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_q_full),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    // Back end: character sequencer plus output register
    jse_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_busy        (w_back_busy),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_char    (o_out_char),
        .o_last_of_run (o_last_of_run)
    );

    // A job is only pushed when the queue has room
    `JSE_ASSERT_IMPL(a_push_room, i_clk, i_rst_n, w_push.valid, !w_q_full, "job pushed into full queue")
    // The back end only pops a job that is there
    `JSE_ASSERT_IMPL(a_pop_head, i_clk, i_rst_n, w_pop, w_head.valid, "pop from empty queue")
    // A popped job keeps the sequencer busy in the next cycle
    `JSE_ASSERT_NEXT(a_pop_busy, i_clk, i_rst_n, w_pop, w_back_busy, "popped job not loaded")

endmodule

// File: dv/tb_json_string_escaper_utf8_unit.sv
// Self-checking testbench for json_string_escaper_utf8_unit.
// Drives UTF-8 bytes, predicts the escaped JSON text per byte, checks each char.
// Depends on jse_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_json_string_escaper_utf8_unit;
    import jse_pkg::*;

    // Run limits. The slowest legal run is roughly 300 bytes x 12 chars with
    // the receiver idling a fifth of the time plus the long hold-off, so this
    // leaves a wide margin.
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 150;
    localparam int IDLE_PCT     = 21;

    // Raw control bytes that get a short escape
    localparam logic [7:0] B_BACKSPACE = 8'h08;
    localparam logic [7:0] B_TAB       = 8'h09;
    localparam logic [7:0] B_NEWLINE   = 8'h0A;
    localparam logic [7:0] B_FORMFEED  = 8'h0C;
    localparam logic [7:0] B_RETURN    = 8'h0D;

    typedef struct {
        logic [6:0] ch;
        logic       last;
    } t_esc_char;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic [7:0] i_in_byte      = 8'h00;
    logic       i_string_start = 1'b0;
    logic       i_out_ready    = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [6:0] o_out_char;
    logic       o_last_of_run;

    json_string_escaper_utf8_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .i_string_start (i_string_start),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_char     (o_out_char),
        .o_last_of_run  (o_last_of_run)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state: continuation bytes still owed and the codepoint so far
    logic [1:0]  utf8_left;
    logic [20:0] cp_accum;

    // Chars owed by the block, oldest first; run_chars stages one byte's worth
    t_esc_char   esc_chars_due[$];
    logic [6:0]  run_chars[$];

    int          err_cnt    = 0;
    int          cycle_cnt  = 0;
    int          bytes_sent = 0;
    bit          idle_on    = 1'b1;   // random idling on both sides
    bit          hold_req   = 1'b0;   // asks the receiver for a long hold-off
    int          hold_left  = 0;

    // \uXXXX with the chosen hex case
    function automatic void push_uesc(input logic [15:0] v, input logic lower);
        logic [3:0] nib;
        run_chars.push_back(CH_BSLASH);
        run_chars.push_back(CH_U);
        for (int k = 3; k >= 0; k--) begin
            nib = v[k*4 +: 4];
            // 0x30 is '0'; 0x57 + 10 is 'a'; 0x37 + 10 is 'A'
            if (nib < 4'd10)
                run_chars.push_back(7'h30 + {3'b000, nib});
            else
                run_chars.push_back((lower ? 7'h57 : 7'h37) + {3'b000, nib});
        end
    endfunction

    // Works out the escaped text that one accepted byte causes and queues it
    function automatic void predict_escape(input logic [7:0] b, input logic fresh);
        logic [20:0] v;
        run_chars.delete();
        // a new string drops whatever sequence was still open
        if (fresh) begin
            utf8_left = 2'd0;
            cp_accum  = '0;
        end
        if (utf8_left != 2'd0) begin
            // continuation taken blindly: only the low six bits count
            cp_accum  = {cp_accum[14:0], b[5:0]};
            utf8_left = utf8_left - 2'd1;
            if (utf8_left != 2'd0)
                return;
            if (cp_accum <= 21'h00FFFF) begin
                push_uesc(cp_accum[15:0], 1'b0);
            end else begin
                // surrogate pair built by OR, no range check above 0x10FFFF
                v = cp_accum - 21'h010000;
                push_uesc(16'hD800 | {5'b00000, v[20:10]}, 1'b0);
                push_uesc(16'hDC00 | {6'b000000, v[9:0]}, 1'b0);
            end
            cp_accum = '0;
        end else if (b == {1'b0, CH_QUOTE} || b == {1'b0, CH_BSLASH}) begin
            run_chars.push_back(CH_BSLASH);
            run_chars.push_back(b[6:0]);
        end else if (b == B_BACKSPACE || b == B_FORMFEED || b == B_NEWLINE ||
                     b == B_RETURN || b == B_TAB) begin
            run_chars.push_back(CH_BSLASH);
            case (b)
                B_BACKSPACE: run_chars.push_back(CH_B);
                B_FORMFEED:  run_chars.push_back(CH_F);
                B_NEWLINE:   run_chars.push_back(CH_N);
                B_RETURN:    run_chars.push_back(CH_R);
                default:     run_chars.push_back(CH_T);
            endcase
        end else if (b < 8'h20) begin
            push_uesc({8'h00, b}, 1'b1);
        end else if (b < 8'h80) begin
            run_chars.push_back(b[6:0]);   // DEL included
        end else if ((b & 8'hE0) == 8'hC0) begin
            cp_accum  = {16'h0000, b[4:0]};
            utf8_left = 2'd1;
            return;
        end else if ((b & 8'hF0) == 8'hE0) begin
            cp_accum  = {17'h00000, b[3:0]};
            utf8_left = 2'd2;
            return;
        end else if ((b & 8'hF8) == 8'hF0) begin
            cp_accum  = {18'h00000, b[2:0]};
            utf8_left = 2'd3;
            return;
        end else begin
            push_uesc(16'hFFFD, 1'b0);   // stray continuation or 0xF8..0xFF
        end
        foreach (run_chars[k])
            esc_chars_due.push_back(t_esc_char'{run_chars[k], k == run_chars.size() - 1});
    endfunction

    // Monitor: predict on each input transfer, then check each output transfer.
    // Both in one process so a same-edge transfer pair can never race.
    always @(posedge i_clk) begin : monitor
        t_esc_char due;
        if (!i_rst_n) begin
            utf8_left = 2'd0;
            cp_accum  = '0;
        end else begin
            if (i_in_valid && o_in_ready)
                predict_escape(i_in_byte, i_string_start);
            if (o_out_valid && i_out_ready) begin
                if (esc_chars_due.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected char %h last %b", o_out_char, o_last_of_run);
                end else begin
                    due = esc_chars_due.pop_front();
                    if (due.ch !== o_out_char || due.last !== o_last_of_run) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("mismatch: exp char %h last %b, got char %h last %b",
                                     due.ch, due.last, o_out_char, o_last_of_run);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: random idling, or a long hold-off counted here on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // One input transfer. Valid stays high back to back unless a gap is drawn;
    // each gap cycle is drawn on its own, so idling matches the receiver's rate.
    task automatic send_byte(input logic [7:0] b, input logic fresh);
        @(negedge i_clk);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_in_byte      <= b;
        i_string_start <= fresh;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
    endtask

    // Well-formed multi-byte sequence with random payload bits
    task automatic send_utf8(input int nbytes, input logic fresh);
        logic [7:0] lead;
        case (nbytes)
            2:       lead = 8'hC0 | 8'($urandom_range(0, 31));
            3:       lead = 8'hE0 | 8'($urandom_range(0, 15));
            default: lead = 8'hF0 | 8'($urandom_range(0, 7));
        endcase
        send_byte(lead, fresh);
        for (int k = 1; k < nbytes; k++)
            send_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
    endtask

    // Mostly valid text with random content, some noise and cut-off sequences
    task automatic send_random_text(input int nbytes);
        int   target;
        int   pick;
        logic fresh;
        target = bytes_sent + nbytes;
        while (bytes_sent < target) begin
            pick  = $urandom_range(0, 99);
            fresh = ($urandom_range(0, 99) < 6);
            if (pick < 35)
                send_byte(8'($urandom_range(8'h20, 8'h7F)), fresh);
            else if (pick < 45)
                send_byte(8'($urandom_range(8'h00, 8'h1F)), fresh);
            else if (pick < 55)
                send_utf8(2, fresh);
            else if (pick < 68)
                send_utf8(3, fresh);
            else if (pick < 80)
                send_utf8(4, fresh);
            else if (pick < 90)
                send_byte(8'($urandom_range(0, 255)), fresh);
            else begin
                // sequence cut short by the start of a new string
                send_byte(8'hE0 | 8'($urandom_range(0, 23)), fresh);
                if ($urandom_range(0, 1))
                    send_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (esc_chars_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Extremes, every escape class, bad leads, all sequence lengths,
    // a sequence above 0x10FFFF, a blind continuation and a dropped sequence
    task automatic test_directed();
        logic [7:0] seq[$];
        seq = '{8'h00, 8'h1F, 8'h20, 8'h7F, {1'b0, CH_QUOTE}, {1'b0, CH_BSLASH},
                B_BACKSPACE, B_FORMFEED, B_NEWLINE, B_RETURN, B_TAB, 8'h80, 8'hFF,
                8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF7, 8'hBF, 8'hBF, 8'hBF,
                8'hC3, 8'h41, 8'hE2};
        foreach (seq[k])
            send_byte(seq[k], k == 0);
        send_byte(8'h41, 1'b1);   // new string drops the open 3-byte sequence
    endtask

    task automatic test_random_mix();
        send_random_text(175);
    endtask

    // Receiver holds off while the sender keeps offering, so the queue fills
    task automatic test_receiver_hold();
        idle_on  = 1'b0;
        hold_req = 1'b1;
        send_random_text(40);
        idle_on  = 1'b1;
    endtask

    // Long stretch at full rate on both sides
    task automatic test_full_rate();
        idle_on = 1'b0;
        send_random_text(40);
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_mix();
        test_receiver_hold();
        test_full_rate();
        wait_drained();

        if (err_cnt == 0 && esc_chars_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
